// ----- rtl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion macros for the RTL of the curvature unit.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define CCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CCC_ASSERT(lbl, clk, rst_n, prop)

`define CCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/ccc_pkg.sv -----
// ============================================================================
// Curvature unit package
// Fixed-point value type, magnitude and saturating add helpers, register codes and latencies.
// ============================================================================
package ccc_pkg;

    localparam int COEFF_W   = 32;
    localparam int RES_W     = 32;
    localparam int REG_IDX_W = 2;

    typedef logic signed [63:0] fx_t;

    typedef struct packed {
        logic clip;
        fx_t  val;
    } fx_res_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LINEAR    = 2'd0,
        REG_QUADRATIC = 2'd1,
        REG_CUBIC     = 2'd2
    } reg_idx_t;

    localparam logic [61:0] MAG_MAX = '1;
    localparam fx_t         ONE_Q24 = 64'sd16777216;

    localparam int MUL_LAT  = 2;
    localparam int SQRT_LAT = 17;
    localparam int DIV_LAT  = 12;

    function automatic logic [61:0] fx_mag(input fx_t v);
        logic [63:0] a;
        a = v[63] ? 64'(-v) : 64'(v);
        return a[61:0];
    endfunction

    function automatic fx_res_t fx_add(input fx_t a, input fx_t b);
        fx_res_t     r;
        fx_t         s;
        logic [63:0] m;
        s = a + b;
        m = s[63] ? 64'(-s) : 64'(s);
        r.clip = (m > 64'(MAG_MAX));
        if (r.clip)
        begin
            m = 64'(MAG_MAX);
        end
        r.val = s[63] ? fx_t'(-m) : fx_t'(m);
        return r;
    endfunction

endpackage

// ----- rtl/ccc_in_if.sv -----
// ============================================================================
// Position channel
// Valid/ready channel carrying one longitudinal position per word.
// ============================================================================
interface ccc_in_if #(
    parameter int POSITION_WIDTH = 32
);
    logic                             valid;
    logic                             ready;
    logic signed [POSITION_WIDTH-1:0] x_position;

    modport source (output valid, output x_position, input ready);
    modport sink (input valid, input x_position, output ready);
endinterface

// ----- rtl/ccc_out_if.sv -----
// ============================================================================
// Result channel
// Valid/ready channel carrying curvature, rate term and saturation flag.
// ============================================================================
interface ccc_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] curvature;
    logic signed [31:0] curvature_rate;
    logic               saturated;

    modport source (output valid, output curvature, output curvature_rate,
                    output saturated, input ready);
    modport sink (input valid, input curvature, input curvature_rate,
                  input saturated, output ready);
endinterface

// ----- rtl/ccc_delay.sv -----
// ============================================================================
// Alignment delay line
// Enable-gated shift line that keeps side values in step with the pipeline.
// ============================================================================
module ccc_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

// ----- rtl/ccc_mul.sv -----
// ============================================================================
// Fixed-point multiplier
// Two-stage Q.24 sign-magnitude multiply with rounding and saturation.
// ============================================================================
module ccc_mul (
    input  logic          clk,
    input  logic          en,
    input  ccc_pkg::fx_t  a,
    input  ccc_pkg::fx_t  b,
    output ccc_pkg::fx_t  y,
    output logic          clip
);
    import ccc_pkg::*;

    logic [61:0]  am;
    logic [61:0]  bm;
    logic [61:0]  ll_reg;
    logic [61:0]  lh_reg;
    logic [61:0]  hl_reg;
    logic [61:0]  hh_reg;
    logic         neg_reg;
    logic [123:0] prod;
    logic [123:0] rnd;
    logic [99:0]  m;
    logic         ovf;
    logic [61:0]  mm;
    fx_t          y_next;
    fx_t          y_reg;
    logic         clip_reg;

    assign am = fx_mag(a);
    assign bm = fx_mag(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg  <= 62'(am[30:0]) * 62'(bm[30:0]);
            lh_reg  <= 62'(am[30:0]) * 62'(bm[61:31]);
            hl_reg  <= 62'(am[61:31]) * 62'(bm[30:0]);
            hh_reg  <= 62'(am[61:31]) * 62'(bm[61:31]);
            neg_reg <= a[63] ^ b[63];
        end
    end

    always_comb
    begin
        prod   = 124'(ll_reg) + (124'(lh_reg) << 31) + (124'(hl_reg) << 31)
               + (124'(hh_reg) << 62);
        rnd    = prod + 124'(24'h80_0000);
        m      = rnd[123:24];
        ovf    = |m[99:62];
        mm     = ovf ? MAG_MAX : m[61:0];
        y_next = neg_reg ? fx_t'(-64'(mm)) : fx_t'(64'(mm));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg    <= y_next;
            clip_reg <= ovf;
        end
    end

    assign y    = y_reg;
    assign clip = clip_reg;
endmodule

// ----- rtl/ccc_sqrt.sv -----
// ============================================================================
// Pipelined square root
// Normalises the operand, then extracts two root bits in each of 16 stages.
// ============================================================================
module ccc_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] s,
    output logic [63:0] r
);
    typedef struct packed {
        logic [35:0] rem;
        logic [31:0] root;
    } sq_t;

    function automatic sq_t sq_step(input sq_t cur, input logic [1:0] pair);
        sq_t         nxt;
        logic [35:0] acc;
        logic [35:0] trial;
        acc   = {cur.rem[33:0], pair};
        trial = {2'b00, cur.root, 2'b01};
        if (acc >= trial)
        begin
            nxt.rem  = acc - trial;
            nxt.root = {cur.root[30:0], 1'b1};
        end
        else
        begin
            nxt.rem  = acc;
            nxt.root = {cur.root[30:0], 1'b0};
        end
        return nxt;
    endfunction

    logic [3:0]  j_sel;
    logic [4:0]  shamt;
    logic [63:0] v_reg [0:15];
    logic [3:0]  j_reg [0:16];
    sq_t         st_reg [0:16];

    always_comb
    begin
        j_sel = 4'd11;
        for (int jj = 11; jj >= 0; jj--)
        begin
            if ((s >> (40 + 2 * jj)) == 64'd0)
            begin
                j_sel = 4'(jj);
            end
        end
        shamt = 5'd24 - 5'({j_sel, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0]  <= s << shamt;
            j_reg[0]  <= j_sel;
            st_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < 16; k++)
    begin : g_stage
        sq_t mid;
        sq_t fin;

        always_comb
        begin
            mid = sq_step(st_reg[k], v_reg[k][63-4*k -: 2]);
            fin = sq_step(mid, v_reg[k][61-4*k -: 2]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k+1] <= fin;
                j_reg[k+1]  <= j_reg[k];
            end
        end

        if (k < 15)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[k+1] <= v_reg[k];
                end
            end
        end
    end

    assign r = 64'(st_reg[16].root) << j_reg[16];
endmodule

// ----- rtl/ccc_div.sv -----
// ============================================================================
// Pipelined Q.24 divider
// Range check, then three restoring quotient bits in each of 11 stages.
// ============================================================================
module ccc_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] n,
    input  logic [63:0] d,
    output logic [32:0] q,
    output logic        ovf
);
    typedef struct packed {
        logic [63:0] rem;
        logic        qb;
    } dv_t;

    function automatic dv_t dv_step(input logic [63:0] rem, input logic [63:0] dv,
                                    input logic nbit);
        dv_t         nxt;
        logic [64:0] acc;
        acc = {rem, nbit};
        if (acc >= 65'(dv))
        begin
            nxt.rem = 64'(acc - 65'(dv));
            nxt.qb  = 1'b1;
        end
        else
        begin
            nxt.rem = acc[63:0];
            nxt.qb  = 1'b0;
        end
        return nxt;
    endfunction

    logic [63:0] rem_reg [0:11];
    logic [63:0] d_reg   [0:10];
    logic [8:0]  nl_reg  [0:10];
    logic [32:0] q_reg   [0:11];
    logic        ovf_reg [0:11];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= 64'(n >> 9);
            d_reg[0]   <= d;
            nl_reg[0]  <= n[8:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= ({9'd0, n} >= {d, 9'd0});
        end
    end

    for (genvar k = 0; k < 11; k++)
    begin : g_stage
        localparam int I0 = 32 - 3 * k;
        logic [32:0] nb;
        dv_t         s0;
        dv_t         s1;
        dv_t         s2;

        always_comb
        begin
            nb = {nl_reg[k], 24'd0};
            s0 = dv_step(rem_reg[k], d_reg[k], nb[I0]);
            s1 = dv_step(s0.rem, d_reg[k], nb[I0-1]);
            s2 = dv_step(s1.rem, d_reg[k], nb[I0-2]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= s2.rem;
                q_reg[k+1]   <= {q_reg[k][29:0], s0.qb, s1.qb, s2.qb};
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < 10)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[k+1]  <= d_reg[k];
                    nl_reg[k+1] <= nl_reg[k];
                end
            end
        end
    end

    assign q   = q_reg[11];
    assign ovf = ovf_reg[11];
endmodule

// ----- rtl/cubic_curve_curvature.sv -----
// ============================================================================
// Cubic lane curvature unit
// Curvature and rate term of a lane cubic at one position per word.
// ============================================================================
// The unit takes one position word per cycle while not stalled and returns
// results in order; the depth is set by the square root, two root bits per
// stage over 16 stages, and by the two dividers, three of their 33 quotient
// bits per stage. When a result waits and the result side holds off, the whole
// pipeline freezes and no word is lost. The user must write the coefficient
// registers only while no word is in flight; the block does not enforce it.
`include "assert_macros.svh"

module cubic_curve_curvature #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [ccc_pkg::REG_IDX_W-1:0]   reg_index,
    input  logic [ccc_pkg::COEFF_W-1:0]     wr_data,
    ccc_in_if.sink                          points,
    ccc_out_if.source                       results
);
    import ccc_pkg::*;

    localparam int LAT = 42;

    logic signed [COEFF_W-1:0] coeff_linear_reg;
    logic signed [COEFF_W-1:0] coeff_quadratic_reg;
    logic signed [COEFF_W-1:0] coeff_cubic_reg;

    logic [LAT:1] vld_reg;
    logic         en;

    fx_t c1;
    fx_t c2x2;
    fx_t c3x3;
    fx_t c3x6;

    logic [POSITION_WIDTH-1:0] raw;
    logic                      xneg;
    logic [POSITION_WIDTH-1:0] xm;
    logic [64:0]               xm_ext;
    logic                      x_ovf;
    logic [61:0]               xmag;
    fx_t                       x_next;
    fx_t                       x_reg;
    logic                      clip1_reg;

    fx_t     x2_w;
    fx_t     t2_w;
    fx_t     t6_w;
    fx_t     t3_w;
    logic    x2_c;
    logic    t2_c;
    logic    t6_c;
    logic    t3_c;
    logic    clip1_d3;
    logic    clip3;
    fx_res_t d2_add;
    fx_t     d2_reg;
    fx_t     t2_4_reg;
    logic    clip4_reg;
    fx_t     t2_5_reg;
    logic    clip5_reg;
    fx_res_t a1;
    fx_res_t a2;
    fx_t     d1_reg;
    logic    clip6_reg;

    fx_t     dd_w;
    fx_t     num_w;
    logic    dd_c;
    logic    num_c;
    logic    clip6;
    fx_t     d1sq_w;
    logic    d1sq_c;
    logic    clip6_d8;
    fx_res_t s_add;
    fx_t     s_reg;
    logic    clip9_reg;

    logic [63:0] r_w;
    logic [64:0] s_clip_d26;
    fx_t         p_w;
    logic        p_c;
    logic        clip_d28;
    logic [127:0] ddnum_d28;
    logic [61:0] d2m_d28;
    fx_res_t     den_add;

    logic [63:0] den_reg;
    logic [63:0] p29_reg;
    logic [61:0] d2m29_reg;
    logic [61:0] numm29_reg;
    logic        numneg29_reg;
    logic        clip29_reg;

    logic [32:0] qc;
    logic        ovfc;
    logic [32:0] qr;
    logic        ovfr;
    logic [1:0]  side_d41;

    logic [31:0]        curv_next;
    logic signed [31:0] rate_next;
    logic               sat_c;
    logic               sat_r;
    logic [31:0]        curv_reg;
    logic signed [31:0] rate_reg;
    logic               sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_linear_reg    <= '0;
            coeff_quadratic_reg <= '0;
            coeff_cubic_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_LINEAR:    coeff_linear_reg    <= wr_data;
                REG_QUADRATIC: coeff_quadratic_reg <= wr_data;
                REG_CUBIC:     coeff_cubic_reg     <= wr_data;
                default:       ;
            endcase
        end
    end

    assign en            = !vld_reg[LAT] || results.ready;
    assign points.ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-1:1], points.valid};
        end
    end

    always_comb
    begin
        c1   = 64'(coeff_linear_reg);
        c2x2 = 64'(coeff_quadratic_reg) + 64'(coeff_quadratic_reg);
        c3x3 = 64'(coeff_cubic_reg) + 64'(coeff_cubic_reg) + 64'(coeff_cubic_reg);
        c3x6 = c3x3 + c3x3;
    end

    always_comb
    begin
        raw    = points.x_position;
        xneg   = raw[POSITION_WIDTH-1];
        xm     = xneg ? POSITION_WIDTH'(~raw + 1'b1) : raw;
        xm_ext = 65'(xm);
        x_ovf  = (xm_ext > 65'(MAG_MAX >> 8));
        xmag   = x_ovf ? MAG_MAX : 62'(xm_ext << 8);
        x_next = xneg ? fx_t'(-64'(xmag)) : fx_t'(64'(xmag));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            clip1_reg <= x_ovf;
        end
    end

    ccc_mul u_mul_x2 (.clk(clk), .en(en), .a(x_reg), .b(x_reg), .y(x2_w), .clip(x2_c));
    ccc_mul u_mul_t2 (.clk(clk), .en(en), .a(c2x2), .b(x_reg), .y(t2_w), .clip(t2_c));
    ccc_mul u_mul_t6 (.clk(clk), .en(en), .a(c3x6), .b(x_reg), .y(t6_w), .clip(t6_c));

    ccc_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_dly_clip1 (
        .clk(clk), .en(en), .d(clip1_reg), .q(clip1_d3)
    );

    assign clip3  = clip1_d3 | x2_c | t2_c | t6_c;
    assign d2_add = fx_add(t6_w, c2x2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg    <= d2_add.val;
            t2_4_reg  <= t2_w;
            clip4_reg <= clip3 | d2_add.clip;
            t2_5_reg  <= t2_4_reg;
            clip5_reg <= clip4_reg;
        end
    end

    ccc_mul u_mul_t3 (.clk(clk), .en(en), .a(c3x3), .b(x2_w), .y(t3_w), .clip(t3_c));

    assign a1 = fx_add(t3_w, t2_5_reg);
    assign a2 = fx_add(a1.val, c1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg    <= a2.val;
            clip6_reg <= clip5_reg | t3_c | a1.clip | a2.clip;
        end
    end

    ccc_mul u_mul_dd (.clk(clk), .en(en), .a(d2_reg), .b(d2_reg), .y(dd_w), .clip(dd_c));
    ccc_mul u_mul_num (.clk(clk), .en(en), .a(c3x6), .b(d2_reg), .y(num_w), .clip(num_c));

    assign clip6 = clip6_reg | dd_c | num_c;

    ccc_mul u_mul_d1 (.clk(clk), .en(en), .a(d1_reg), .b(d1_reg), .y(d1sq_w), .clip(d1sq_c));

    ccc_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_dly_clip6 (
        .clk(clk), .en(en), .d(clip6), .q(clip6_d8)
    );

    assign s_add = fx_add(d1sq_w, ONE_Q24);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg     <= s_add.val;
            clip9_reg <= clip6_d8 | d1sq_c | s_add.clip;
        end
    end

    ccc_sqrt u_sqrt (.clk(clk), .en(en), .s(s_reg), .r(r_w));

    ccc_delay #(.WIDTH(65), .DEPTH(SQRT_LAT)) u_dly_s (
        .clk(clk), .en(en), .d({clip9_reg, s_reg}), .q(s_clip_d26)
    );

    ccc_mul u_mul_p (
        .clk(clk), .en(en), .a(fx_t'(s_clip_d26[63:0])), .b(fx_t'(r_w)),
        .y(p_w), .clip(p_c)
    );

    ccc_delay #(.WIDTH(1), .DEPTH(MUL_LAT)) u_dly_clip26 (
        .clk(clk), .en(en), .d(s_clip_d26[64]), .q(clip_d28)
    );

    ccc_delay #(.WIDTH(128), .DEPTH(2 * MUL_LAT + SQRT_LAT + 1)) u_dly_ddnum (
        .clk(clk), .en(en), .d({dd_w, num_w}), .q(ddnum_d28)
    );

    ccc_delay #(.WIDTH(62), .DEPTH(3 * MUL_LAT + SQRT_LAT + 1)) u_dly_d2m (
        .clk(clk), .en(en), .d(fx_mag(d2_reg)), .q(d2m_d28)
    );

    assign den_add = fx_add(fx_t'(ddnum_d28[127:64]), p_w);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg      <= 64'(den_add.val);
            p29_reg      <= 64'(p_w);
            d2m29_reg    <= d2m_d28;
            numm29_reg   <= fx_mag(fx_t'(ddnum_d28[63:0]));
            numneg29_reg <= ddnum_d28[63];
            clip29_reg   <= clip_d28 | p_c | den_add.clip;
        end
    end

    // Both divisors are at least one, since the sum under the root is at least one.
    ccc_div u_div_curv (
        .clk(clk), .en(en), .n(64'(d2m29_reg)), .d(p29_reg), .q(qc), .ovf(ovfc)
    );

    ccc_div u_div_rate (
        .clk(clk), .en(en), .n(64'(numm29_reg)), .d(den_reg), .q(qr), .ovf(ovfr)
    );

    ccc_delay #(.WIDTH(2), .DEPTH(DIV_LAT)) u_dly_side (
        .clk(clk), .en(en), .d({clip29_reg, numneg29_reg}), .q(side_d41)
    );

    always_comb
    begin
        sat_c     = ovfc | qc[32];
        curv_next = sat_c ? 32'hFFFF_FFFF : qc[31:0];
        if (side_d41[0])
        begin
            sat_r     = ovfr | qr[32] | (qr[31:0] > 32'h8000_0000);
            rate_next = sat_r ? 32'sh8000_0000 : 32'(-qr[31:0]);
        end
        else
        begin
            sat_r     = ovfr | qr[32] | qr[31];
            rate_next = sat_r ? 32'sh7FFF_FFFF : 32'(qr[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            curv_reg <= curv_next;
            rate_reg <= rate_next;
            sat_reg  <= side_d41[1] | sat_c | sat_r;
        end
    end

    assign results.valid          = vld_reg[LAT];
    assign results.curvature      = curv_reg;
    assign results.curvature_rate = rate_reg;
    assign results.saturated      = sat_reg;

    `CCC_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !en, $stable(vld_reg))
    `CCC_ASSERT_NEXT(a_accept_enters, clk, rst_n, points.valid && points.ready, vld_reg[1])
    `CCC_ASSERT(a_rise_needs_en, clk, rst_n, !$rose(results.valid) || $past(en))
endmodule

// ----- test/cubic_curve_curvature_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Curvature unit checker
// Watches the coefficient writes and both channels. It predicts the result
// word of every accepted position word in fixed point and compares each
// accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module cubic_curve_curvature_chk
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [ccc_pkg::REG_IDX_W-1:0] reg_index,
    input  logic [ccc_pkg::COEFF_W-1:0]   wr_data,
    ccc_in_if                             points,
    ccc_out_if                            results,
    output int                            errors,
    output int                            pending
);
    import ccc_pkg::*;

    localparam longint unsigned MAG_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned QUOT_CAP  = 64'h1_0000_0000_00;

    typedef struct packed {
        logic [31:0] curvature;
        logic [31:0] curvature_rate;
        logic        saturated;
    } curv_word_t;

    logic [31:0] coeff_lin;
    logic [31:0] coeff_quad;
    logic [31:0] coeff_cub;
    curv_word_t  expected_words[$];

    function automatic longint unsigned mag64(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint signed_mag(input bit neg, input logic [127:0] m,
                                          inout bit clip);
        longint unsigned u;
        if (m > 128'(MAG_LIMIT))
        begin
            m    = 128'(MAG_LIMIT);
            clip = 1'b1;
        end
        u = m[63:0];
        return neg ? -longint'(u) : longint'(u);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b, inout bit clip);
        logic [127:0] prod;
        prod = 128'(mag64(a)) * 128'(mag64(b)) + 128'(1 << 23);
        return signed_mag((a < 0) != (b < 0), prod >> 24, clip);
    endfunction

    function automatic longint fx_sum(input longint a, input longint b, inout bit clip);
        longint s;
        s = a + b;
        return signed_mag(s < 0, 128'(mag64(s)), clip);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned quot_q24(input longint unsigned n,
                                                 input longint unsigned d);
        logic [127:0] q;
        q = (128'(n) << 24) / 128'(d);
        if (q > 128'(QUOT_CAP))
            q = 128'(QUOT_CAP);
        return q[63:0];
    endfunction

    function automatic curv_word_t predict_curvature(input logic [31:0] xraw);
        curv_word_t      w;
        bit              clip;
        longint          x, c1, c2, c3, x2, d1, d2, d3, s, p, num, dsum;
        longint unsigned xm, su, r, q;
        int              j;
        clip = 1'b0;
        xm   = xraw[31] ? 64'(32'(-xraw)) : 64'(xraw);
        x    = xraw[31] ? -longint'(xm << 8) : longint'(xm << 8);
        c1   = longint'(signed'(coeff_lin));
        c2   = longint'(signed'(coeff_quad));
        c3   = longint'(signed'(coeff_cub));
        x2   = fx_mul(x, x, clip);
        d1   = fx_sum(fx_sum(fx_mul(3 * c3, x2, clip), fx_mul(2 * c2, x, clip), clip),
                      c1, clip);
        d2   = fx_sum(fx_mul(6 * c3, x, clip), 2 * c2, clip);
        d3   = 6 * c3;
        s    = fx_sum(fx_mul(d1, d1, clip), longint'(ONE_Q24), clip);
        su   = s;
        j    = 0;
        while (j < 11 && su > (64'hFFFF_FFFF_FFFF_FFFF >> (24 - 2 * j)))
            j++;
        r = int_sqrt(su << (24 - 2 * j)) << j;
        p = fx_mul(s, longint'(r), clip);
        q = (p > 0) ? quot_q24(mag64(d2), p) : 0;
        if (q > 64'hFFFF_FFFF)
        begin
            q    = 64'hFFFF_FFFF;
            clip = 1'b1;
        end
        w.curvature = q[31:0];
        num  = fx_mul(d3, d2, clip);
        dsum = fx_sum(fx_mul(d2, d2, clip), p, clip);
        if (dsum == 0)
            w.curvature_rate = '0;
        else
        begin
            q = quot_q24(mag64(num), dsum);
            if (num < 0)
            begin
                if (q > 64'h8000_0000)
                begin
                    q    = 64'h8000_0000;
                    clip = 1'b1;
                end
                w.curvature_rate = 32'(-q);
            end
            else
            begin
                if (q > 64'h7FFF_FFFF)
                begin
                    q    = 64'h7FFF_FFFF;
                    clip = 1'b1;
                end
                w.curvature_rate = q[31:0];
            end
        end
        w.saturated = clip;
        return w;
    endfunction

    assign pending = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        curv_word_t want;
        if (!rst_n)
        begin
            coeff_lin  <= '0;
            coeff_quad <= '0;
            coeff_cub  <= '0;
            errors     = 0;
            expected_words.delete();
        end
        else
        begin
            if (points.valid && points.ready)
                expected_words.push_back(predict_curvature(32'(points.x_position)));
            if (results.valid && results.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result word %h %h %b", $time,
                             results.curvature, results.curvature_rate, results.saturated);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want.curvature !== results.curvature)
                    begin
                        $display("%0t: curvature expected %h actual %h", $time,
                                 want.curvature, results.curvature);
                        errors++;
                    end
                    if (want.curvature_rate !== results.curvature_rate)
                    begin
                        $display("%0t: curvature_rate expected %h actual %h", $time,
                                 want.curvature_rate, results.curvature_rate);
                        errors++;
                    end
                    if (want.saturated !== results.saturated)
                    begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, results.saturated);
                        errors++;
                    end
                end
            end
            if (wr_en)
            begin
                case (reg_index)
                    REG_LINEAR:    coeff_lin  <= wr_data;
                    REG_QUADRATIC: coeff_quad <= wr_data;
                    REG_CUBIC:     coeff_cub  <= wr_data;
                    default:       ;
                endcase
            end
        end
    end
endmodule

// ----- test/cubic_curve_curvature_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Curvature unit testbench
// Drives position words through the cubic curvature unit under several
// coefficient settings and idling patterns; a checker beside the unit
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module cubic_curve_curvature_tb;
    import ccc_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [31:0] CORNER_POS [8] = '{32'h0, 32'h1, 32'hFFFF_FFFF,
                                               32'h7FFF_FFFF, 32'h8000_0000,
                                               32'h0001_0000, 32'hFFFF_0000,
                                               32'h0064_0000};

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_index;
    logic [COEFF_W-1:0]   wr_data;
    int                   errors;
    int                   pending;
    int                   send_idle;
    int                   recv_idle;

    ccc_in_if #(.POSITION_WIDTH(32)) pts();
    ccc_out_if                       res();

    cubic_curve_curvature #(.POSITION_WIDTH(32)) u_dut
    (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .reg_index(reg_index),
        .wr_data(wr_data), .points(pts), .results(res)
    );

    cubic_curve_curvature_chk u_chk
    (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .reg_index(reg_index),
        .wr_data(wr_data), .points(pts), .results(res),
        .errors(errors), .pending(pending)
    );

    always #10 clk = ~clk;

    task automatic send_position(input logic [31:0] x);
        while ($urandom_range(0, 99) < send_idle)
        begin
            pts.valid = 1'b0;
            @(negedge clk);
        end
        pts.valid      = 1'b1;
        pts.x_position = x;
        do
            @(posedge clk);
        while (!pts.ready);
        @(negedge clk);
    endtask

    task automatic drain;
        pts.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_coeff(input logic [REG_IDX_W-1:0] idx, input logic [31:0] v);
        wr_en     = 1'b1;
        reg_index = idx;
        wr_data   = v;
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    task automatic load_coeffs(input logic [31:0] c1, input logic [31:0] c2,
                               input logic [31:0] c3);
        drain();
        write_coeff(REG_LINEAR, c1);
        write_coeff(REG_QUADRATIC, c2);
        write_coeff(REG_CUBIC, c3);
    endtask

    function automatic logic [31:0] rand_coeff();
        int v;
        v = $urandom;
        if ($urandom_range(0, 9) == 0)
            return v;
        return v >>> $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] rand_position();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 200 << 16) - (100 << 16);
        return $urandom;
    endfunction

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        reg_index = REG_LINEAR;
        wr_data   = '0;
        pts.valid = 1'b0;
        pts.x_position = '0;
        send_idle = 0;
        recv_idle = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle = 21;
        recv_idle = 54;
        send_position(32'h0000_0000);
        send_position(32'h0001_0000);
        load_coeffs(32'h0020_0000, 32'h0100_0000, 32'h0001_0000);
        foreach (CORNER_POS[i])
            send_position(CORNER_POS[i]);
        load_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_position(32'h7FFF_FFFF);
        send_position(32'h8000_0000);
        send_position(32'h0000_0100);
        load_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_position(32'h7FFF_FFFF);
        send_position(32'h8000_0000);
        send_position(32'h0000_0000);
        load_coeffs(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        send_position(32'h0010_0000);
        send_position(32'hFFF0_0000);
        drain();
        write_coeff(REG_UNUSED, 32'hDEAD_BEEF);
        send_position(32'h0003_0000);

        for (int phase = 0; phase < 6; phase++)
        begin
            load_coeffs(rand_coeff(), rand_coeff(), rand_coeff());
            send_idle = (phase < 2) ? 21 : (phase < 4) ? 54 : 0;
            recv_idle = (phase < 2) ? 54 : (phase < 4) ? 21 : 0;
            for (int n = 0; n < 320; n++)
            begin
                if (phase == 0 && n == 160)
                begin
                    pts.valid = 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                end
                send_position(rand_position());
            end
        end

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            res.ready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ccc_pkg.sv
rtl/ccc_in_if.sv
rtl/ccc_out_if.sv
rtl/ccc_delay.sv
rtl/ccc_mul.sv
rtl/ccc_sqrt.sv
rtl/ccc_div.sv
rtl/cubic_curve_curvature.sv
test/cubic_curve_curvature_chk.sv
test/cubic_curve_curvature_tb.sv
